// ===== hdl/nmeadt_pkg.sv =====
// Shared types and constants for the NMEA depth and temperature sentence parser.
`default_nettype none
package nmeadt_pkg;

    localparam int DEPTH_W = 21;   // reading width, two's complement
    localparam int MAG_W   = 20;   // magnitude accumulator width
    localparam int IDX_W   = 3;    // field index, saturates at 7
    localparam int ID_LEN  = 6;    // sentence name length

    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(999999);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Sentence names, first character in the top byte
    localparam logic [8*ID_LEN-1:0] ID_DEPTH  = "$SDDPT";
    localparam logic [8*ID_LEN-1:0] ID_TEMP_A = "$YXMTW";
    localparam logic [8*ID_LEN-1:0] ID_TEMP_B = "$SDMTW";

    typedef enum logic {
        OP_RX_BYTE     = 1'b0,
        OP_WRITE_VALID = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] data_byte;
        logic       valid_value;
    } t_item;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_tenths;
        logic [DEPTH_W-1:0] temperature_tenths;
        logic               reading_valid;
        logic               line_done;
        logic               line_overflow;
    } t_result;

    // Per-name match bits for one character of field 0: bit 0 depth,
    // bit 1 and bit 2 the two temperature names.
    function automatic logic [2:0] id_char_match(input logic [2:0] pos, input logic [7:0] c);
        logic [2:0] m;
        int         sh;
        m  = 3'b000;
        sh = 0;
        if (pos < 3'(ID_LEN)) begin
            sh   = 8 * (ID_LEN - 1 - int'(pos));
            m[0] = (ID_DEPTH[sh +: 8] == c);
            m[1] = (ID_TEMP_A[sh +: 8] == c);
            m[2] = (ID_TEMP_B[sh +: 8] == c);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nmeadt_core.sv =====
// Line, field and number parsing state with its next-state update.
`default_nettype none
module nmeadt_core #(
    parameter int LINE_LIMIT  = 100,
    parameter int FIELD_LIMIT = 20
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  wire                   i_enable,
    input  nmeadt_pkg::t_item     i_item,
    output nmeadt_pkg::t_result   o_result
);
    import nmeadt_pkg::*;

    localparam int LL_W = $clog2(LINE_LIMIT + 1);
    localparam int FC_W = $clog2(FIELD_LIMIT + 1);

    logic [LL_W-1:0]    r_line_length,  n_line_length;
    logic [IDX_W-1:0]   r_field_index,  n_field_index;
    logic [FC_W-1:0]    r_char_count,   n_char_count;
    logic [2:0]         r_id_flags,     n_id_flags;
    logic [MAG_W-1:0]   r_acc,          n_acc;
    t_phase             r_phase,        n_phase;
    logic               r_negative,     n_negative;
    logic [DEPTH_W-1:0] r_depth,        n_depth;
    logic [DEPTH_W-1:0] r_temp,         n_temp;
    logic               r_valid,        n_valid;
    logic               r_overflow,     n_overflow;

    logic [7:0]         c;
    logic               is_digit;
    logic [3:0]         digit;
    logic [MAG_W+3:0]   int_sum;
    logic [MAG_W:0]     frac_sum;
    logic [2:0]         end_flags;
    logic [DEPTH_W-1:0] end_value;
    logic               done;
    logic               ovf_report;

    assign c        = i_item.data_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = is_digit ? 4'(c - CH_ZERO) : 4'd0;
    // (acc + d) * 10
    assign int_sum  = ((MAG_W+4)'(r_acc) + (MAG_W+4)'(digit)) * (MAG_W+4)'(10);
    assign frac_sum = (MAG_W+1)'(r_acc) + (MAG_W+1)'(digit);

    always_comb begin
        end_flags = r_id_flags;
        if (r_field_index == '0 && r_char_count != FC_W'(ID_LEN)) begin
            end_flags = 3'b000;
        end
        end_value = r_negative ? DEPTH_W'(-{1'b0, r_acc}) : DEPTH_W'({1'b0, r_acc});
    end

    always_comb begin
        n_line_length = r_line_length;
        n_field_index = r_field_index;
        n_char_count  = r_char_count;
        n_id_flags    = r_id_flags;
        n_acc         = r_acc;
        n_phase       = r_phase;
        n_negative    = r_negative;
        n_depth       = r_depth;
        n_temp        = r_temp;
        n_valid       = r_valid;
        n_overflow    = r_overflow;
        done          = 1'b0;

        if (i_item.opcode == OP_WRITE_VALID) begin
            n_valid = i_item.valid_value;
        end else if (i_enable) begin
            if (c == CH_LF) begin
                done = 1'b1;
                if (end_flags[0]) begin
                    n_depth = end_value;
                    n_valid = 1'b1;
                end
                if (end_flags[2:1] != 2'b00) begin
                    n_temp  = end_value;
                    n_valid = 1'b1;
                end
                n_line_length = '0;
                n_field_index = '0;
                n_char_count  = '0;
                n_id_flags    = 3'b111;
                n_acc         = '0;
                n_phase       = PH_START;
                n_negative    = 1'b0;
            end else if (c != CH_TAB && (c < CH_SPACE || c > CH_TILDE)) begin
                // drop control and high bytes
            end else if (r_line_length >= LL_W'(LINE_LIMIT)) begin
                n_overflow = 1'b1;
            end else begin
                n_line_length = r_line_length + 1'b1;
                if (c == CH_SPACE) begin
                    // drop spaces after counting them
                end else if (c == CH_COMMA) begin
                    if (r_field_index == '0 && r_char_count != FC_W'(ID_LEN)) begin
                        n_id_flags = 3'b000;
                    end
                    if (r_field_index != '1) begin
                        n_field_index = r_field_index + 1'b1;
                    end
                    n_char_count = '0;
                end else if (r_char_count >= FC_W'(FIELD_LIMIT)) begin
                    if (r_field_index == '0) begin
                        n_id_flags = 3'b000;
                    end
                end else begin
                    n_char_count = r_char_count + 1'b1;
                    if (r_field_index == '0) begin
                        if (r_char_count >= FC_W'(ID_LEN)) begin
                            n_id_flags = 3'b000;
                        end else begin
                            n_id_flags = r_id_flags & id_char_match(r_char_count[2:0], c);
                        end
                    end else if (r_field_index == IDX_W'(1)) begin
                        if (r_phase == PH_START && c == CH_TAB) begin
                            // skip leading tabs
                        end else if (r_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
                            n_negative = (c == CH_MINUS);
                            n_phase    = PH_INT;
                        end else if ((r_phase == PH_START || r_phase == PH_INT) && is_digit) begin
                            n_acc   = (int_sum > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX
                                                                      : int_sum[MAG_W-1:0];
                            n_phase = PH_INT;
                        end else if ((r_phase == PH_START || r_phase == PH_INT)
                                     && c == CH_POINT) begin
                            n_phase = PH_FRAC;
                        end else if (r_phase == PH_FRAC && is_digit) begin
                            n_acc   = (frac_sum > (MAG_W+1)'(MAG_MAX)) ? MAG_MAX
                                                                       : frac_sum[MAG_W-1:0];
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
        end

        ovf_report = n_overflow;
        if (done) begin
            n_overflow = 1'b0;
        end
    end

    always_comb begin
        o_result.depth_tenths       = n_depth;
        o_result.temperature_tenths = n_temp;
        o_result.reading_valid      = n_valid;
        o_result.line_done          = done;
        o_result.line_overflow      = ovf_report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= '0;
            r_field_index <= '0;
            r_char_count  <= '0;
            r_id_flags    <= 3'b111;
            r_acc         <= '0;
            r_phase       <= PH_START;
            r_negative    <= 1'b0;
            r_depth       <= '0;
            r_temp        <= '0;
            r_valid       <= 1'b0;
            r_overflow    <= 1'b0;
        end else if (i_step) begin
            r_line_length <= n_line_length;
            r_field_index <= n_field_index;
            r_char_count  <= n_char_count;
            r_id_flags    <= n_id_flags;
            r_acc         <= n_acc;
            r_phase       <= n_phase;
            r_negative    <= n_negative;
            r_depth       <= n_depth;
            r_temp        <= n_temp;
            r_valid       <= n_valid;
            r_overflow    <= n_overflow;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/nmea_depth_temp_sentence_parser.sv =====
// Top level of the NMEA depth and water temperature sentence parser.
// The block takes one transaction per received UART byte (or a write of the
// reading-valid flag) and returns exactly one result transaction for each.
// Bytes are assembled into lines ended by LF; CR, NUL, XON, XOFF and other
// non-printable bytes except tab are dropped, spaces are removed and commas
// split fields. At LF, a field 0 of "$SDDPT" updates depth and "$YXMTW" or
// "$SDMTW" updates temperature, from field 1 read as a signed decimal in
// tenths (one fraction digit, truncated, magnitude saturated at 999999).
// Lines longer than LINE_LIMIT kept bytes lose the rest and raise
// line_overflow up to and including the result of their LF. Throughput is
// one transaction per clock while i_m_tready does not stall the result
// stream; the input register feeds the parser, and the result register
// takes its output once it is empty or being read. Each result carries
// the current depth, temperature and valid flag. Set sensing_enable
// (address 0, bit 0) to let bytes through; with it clear bytes change
// nothing.
`default_nettype none
module nmea_depth_temp_sentence_parser #(
    parameter int LINE_LIMIT  = 100,
    parameter int FIELD_LIMIT = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration port
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // Input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [7:0] data_byte, [8] valid_value, zero pad
    input  wire         i_s_tuser,   // [0] opcode
    // Result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // [20:0] depth_tenths, [41:21] temperature_tenths,
                                     // [42] reading_valid, [43] line_overflow, zero pad
    output logic        o_m_tlast    // line_done
);
    import nmeadt_pkg::*;

    logic    r_enable;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    // Config register: write on the APB access phase, register index in paddr[2]
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == 1'b0) ? {31'd0, r_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && o_pready && i_paddr[2] == 1'b0) begin
            r_enable <= i_pwdata[0];
        end
    end

    // Advance the parser when an item waits and the result register frees up
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the payload until the parser takes it
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.opcode      <= t_opcode'(i_s_tuser);
            r_in_item.data_byte   <= i_s_tdata[7:0];
            r_in_item.valid_value <= i_s_tdata[8];
        end
    end

    nmeadt_core #(
        .LINE_LIMIT  (LINE_LIMIT),
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_enable (r_enable),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // Result register: load on advance, drop once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.line_overflow, r_out.reading_valid,
                         r_out.temperature_tenths, r_out.depth_tenths};
    assign o_m_tlast  = r_out.line_done;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the NMEA depth and temperature sentence parser.
`timescale 1ns / 100ps
module tb;
    import nmeadt_pkg::*;

    localparam int LINE_LIMIT     = 100;
    localparam int FIELD_LIMIT    = 20;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transaction
    localparam int DRAIN_CYCLES   = 8;      // pipeline latency plus margin

    localparam logic [2:0] REG_SENSING_ENABLE = 3'd0;

    // Bytes the parser must drop
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    nmea_depth_temp_sentence_parser #(
        .LINE_LIMIT  (LINE_LIMIT),
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] data_byte, [8] valid_value, zero pad
        .i_s_tuser  (s_tuser),    // [0] opcode
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [20:0] depth, [41:21] temperature, [42] valid,
                                  // [43] line_overflow, zero pad
        .o_m_tlast  (m_tlast)     // line_done
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Parser predictor: its own copy of the configuration and line state
    // ------------------------------------------------------------------
    logic               sensing_on;
    logic [6:0]         kept_bytes;       // bytes kept in the current line
    logic [IDX_W-1:0]   field_num;        // saturates at 7
    logic [4:0]         field_len;        // characters kept in this field
    logic [2:0]         name_hits;        // bit 0 depth, bits 1 and 2 temperature
    logic [MAG_W-1:0]   value_mag;        // magnitude in tenths
    t_phase             value_phase;
    logic               value_neg;
    logic [DEPTH_W-1:0] depth_now;
    logic [DEPTH_W-1:0] temp_now;
    logic               reading_ok;
    logic               overflow_seen;

    t_result expected_readings[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    bit      calm           = 1'b0;       // suppress all idling on both sides

    function automatic void restart_line();
        kept_bytes  = '0;
        field_num   = '0;
        field_len   = '0;
        name_hits   = 3'b111;
        value_mag   = '0;
        value_phase = PH_START;
        value_neg   = 1'b0;
    endfunction

    function automatic void match_name_char(logic [7:0] c);
        int sh;
        if (field_len >= ID_LEN) begin
            name_hits = 3'b000;
            return;
        end
        sh = 8 * (ID_LEN - 1 - int'(field_len));
        if (ID_DEPTH[sh +: 8] != c)  name_hits[0] = 1'b0;
        if (ID_TEMP_A[sh +: 8] != c) name_hits[1] = 1'b0;
        if (ID_TEMP_B[sh +: 8] != c) name_hits[2] = 1'b0;
    endfunction

    // Signed decimal in tenths: tabs, sign, integer digits, point, one fraction digit
    function automatic void accumulate_digit(logic [7:0] c);
        bit          is_digit;
        int unsigned d;
        int unsigned v;
        bit          leading;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = is_digit ? int'(c - CH_ZERO) : 0;
        leading  = (value_phase == PH_START) || (value_phase == PH_INT);
        if (value_phase == PH_START && c == CH_TAB) return;
        if (value_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
            value_neg   = (c == CH_MINUS);
            value_phase = PH_INT;
        end else if (leading && is_digit) begin
            v           = value_mag * 10 + d * 10;
            value_mag   = (v > MAG_MAX) ? MAG_MAX : MAG_W'(v);
            value_phase = PH_INT;
        end else if (leading && c == CH_POINT) begin
            value_phase = PH_FRAC;
        end else if (value_phase == PH_FRAC && is_digit) begin
            v           = value_mag + d;
            value_mag   = (v > MAG_MAX) ? MAG_MAX : MAG_W'(v);
            value_phase = PH_DONE;
        end else begin
            value_phase = PH_DONE;
        end
    endfunction

    function automatic void close_line();
        logic [2:0]         hits;
        logic [DEPTH_W-1:0] reading;
        hits = name_hits;
        if (field_num == 0 && field_len != 5'(ID_LEN)) hits = 3'b000;
        reading = {1'b0, value_mag};
        if (value_neg) reading = -reading;
        if (hits[0]) begin
            depth_now  = reading;
            reading_ok = 1'b1;
        end
        if (hits[2:1] != 2'b00) begin
            temp_now   = reading;
            reading_ok = 1'b1;
        end
        restart_line();
    endfunction

    function automatic void take_serial_byte(logic [7:0] c);
        if (c == CH_LF) begin
            close_line();
            return;
        end
        if (c != CH_TAB && (c < CH_SPACE || c > CH_TILDE)) return;
        if (kept_bytes >= LINE_LIMIT) begin
            overflow_seen = 1'b1;
            return;
        end
        kept_bytes++;
        if (c == CH_SPACE) return;
        if (c == CH_COMMA) begin
            if (field_num == 0 && field_len != 5'(ID_LEN)) name_hits = 3'b000;
            if (field_num != '1) field_num++;
            field_len = '0;
            return;
        end
        if (field_len >= FIELD_LIMIT) begin
            if (field_num == 0) name_hits = 3'b000;
            return;
        end
        if (field_num == 0) match_name_char(c);
        else if (field_num == 1) accumulate_digit(c);
        field_len++;
    endfunction

    function automatic t_result parse_step(t_item it);
        t_result r;
        logic    ended;
        ended = 1'b0;
        if (it.opcode == OP_WRITE_VALID) begin
            reading_ok = it.valid_value;
        end else if (sensing_on) begin
            take_serial_byte(it.data_byte);
            ended = (it.data_byte == CH_LF);
        end
        r.depth_tenths       = depth_now;
        r.temperature_tenths = temp_now;
        r.reading_valid      = reading_ok;
        r.line_done          = ended;
        r.line_overflow      = overflow_seen;
        if (ended) overflow_seen = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idling: mostly short gaps, a few long ones, none while calm
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: hold tready low for a random stall, then raise it
    int rx_stall_left = 0;
    always @(negedge i_clk) begin
        int g;
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            g = pick_gap();
            m_tready <= (g == 0);
            if (g > 0) rx_stall_left = g - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int exp_v, int act_v);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.depth_tenths       = m_tdata[20:0];
            got.temperature_tenths = m_tdata[41:21];
            got.reading_valid      = m_tdata[42];
            got.line_overflow      = m_tdata[43];
            got.line_done          = m_tlast;
            if (expected_readings.size() == 0) begin
                $display("%0t ns: unexpected result, actual depth %0d temperature %0d",
                         $time, $signed(got.depth_tenths), $signed(got.temperature_tenths));
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                if (want.depth_tenths !== got.depth_tenths)
                    report_mismatch("depth_tenths", $signed(want.depth_tenths),
                                    $signed(got.depth_tenths));
                if (want.temperature_tenths !== got.temperature_tenths)
                    report_mismatch("temperature_tenths", $signed(want.temperature_tenths),
                                    $signed(got.temperature_tenths));
                if (want.reading_valid !== got.reading_valid)
                    report_mismatch("reading_valid", want.reading_valid, got.reading_valid);
                if (want.line_done !== got.line_done)
                    report_mismatch("line_done", want.line_done, got.line_done);
                if (want.line_overflow !== got.line_overflow)
                    report_mismatch("line_overflow", want.line_overflow, got.line_overflow);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Present one item at the falling edge, hold it until the rising edge that
    // accepts it, then predict its result. tvalid stays high between
    // back-to-back items and only drops during a gap.
    task automatic send_item(t_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.valid_value, it.data_byte};
        s_tuser  <= it.opcode;
        do @(posedge i_clk); while (!s_tready);
        expected_readings.push_back(parse_step(it));
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        send_item('{opcode: OP_RX_BYTE, data_byte: c, valid_value: 1'($urandom_range(0, 1))});
    endtask

    task automatic send_valid_write(logic v);
        send_item('{opcode: OP_WRITE_VALID, data_byte: 8'($urandom_range(0, 255)),
                    valid_value: v});
    endtask

    // Drop tvalid and wait until every predicted result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic write_config(logic [2:0] addr, logic [31:0] value);
        logic [31:0] readback;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_SENSING_ENABLE) sensing_on = value[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Read the register back
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {31'b0, sensing_on})
            report_mismatch("sensing_enable readback", sensing_on, readback);
    endtask

    // ------------------------------------------------------------------
    // Sentence generation
    // ------------------------------------------------------------------
    logic [7:0] line_bytes[$];

    function automatic logic [7:0] dropped_byte();
        case ($urandom_range(0, 6))
            0:       return CH_NUL;
            1:       return CH_CR;
            2:       return CH_XON;
            3:       return CH_XOFF;
            4:       return 8'($urandom_range(1, 8));
            5:       return 8'($urandom_range(8'h0B, 8'h1F));
            default: return 8'($urandom_range(CH_DEL, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    // Queue one character, sometimes after a dropped byte or a space
    function automatic void push_char(logic [7:0] c);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) line_bytes.push_back(dropped_byte());
        else if (r < 10) line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(c);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic string sentence_name();
        string names[3];
        string s;
        int    n;
        names = '{"$SDDPT", "$YXMTW", "$SDMTW"};
        case ($urandom_range(0, 9))
            0, 1, 2: s = names[0];
            3, 4:    s = names[1];
            5, 6:    s = names[2];
            7: begin
                // one character off
                s = names[$urandom_range(0, 2)];
                s.putc($urandom_range(0, ID_LEN - 1), printable());
            end
            8: s = ($urandom_range(0, 1) == 0) ? "$SDDP" : "$SDDPTX";
            default: begin
                s = "";
                n = $urandom_range(0, 25);
                repeat (n) s = {s, string'(printable())};
            end
        endcase
        return s;
    endfunction

    // Field 1: tabs, sign, integer digits, point, fraction digits, maybe junk
    function automatic void push_number();
        int n;
        int r;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) push_char(CH_TAB);
        r = $urandom_range(0, 99);
        if (r < 30) push_char(CH_MINUS);
        else if (r < 45) push_char(CH_PLUS);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        repeat (n) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 6) begin
            push_char(CH_POINT);
            repeat ($urandom_range(0, 3)) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       push_text("e2");
                1:       push_char(CH_POINT);
                2:       push_char(CH_MINUS);
                default: push_char(printable());
            endcase
        end
    endfunction

    function automatic void make_line();
        int n;
        line_bytes.delete();
        if ($urandom_range(0, 99) < 8) begin
            // broken line of raw noise
            repeat ($urandom_range(1, 30)) line_bytes.push_back(8'($urandom_range(0, 255)));
            line_bytes.push_back(CH_LF);
            return;
        end
        push_text(sentence_name());
        if ($urandom_range(0, 9) != 0) begin
            push_char(CH_COMMA);
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(FIELD_LIMIT - 2, FIELD_LIMIT + 6))
                    push_char(8'(CH_ZERO + $urandom_range(0, 9)));
            else
                push_number();
            repeat ($urandom_range(0, 5)) begin
                push_char(CH_COMMA);
                n = ($urandom_range(0, 19) == 0) ? 25 : $urandom_range(0, 6);
                repeat (n) push_char(printable());
            end
        end
        // pad past the line limit now and then
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(LINE_LIMIT - 10, LINE_LIMIT + 40)) push_char(printable());
        if ($urandom_range(0, 4) == 0) push_text("*5A");
        if ($urandom_range(0, 1) == 0) line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        sensing_on    = 1'b0;
        depth_now     = '0;
        temp_now      = '0;
        reading_ok    = 1'b0;
        overflow_seen = 1'b0;
        restart_line();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Both opcodes, dropped bytes, leading tab and a depth sentence with CR LF
    task automatic test_directed_cases();
        string      s;
        logic [7:0] drops[6];
        drops = '{CH_NUL, 8'hFF, CH_DEL, CH_CR, CH_XON, CH_XOFF};
        write_config(REG_SENSING_ENABLE, 32'd1);
        send_valid_write(1'b1);
        send_valid_write(1'b0);
        foreach (drops[i]) send_byte(drops[i]);
        s = "$SDDPT,";
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(CH_TAB);
        s = "-9.87";
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // With sensing off, every byte must leave the parser untouched
    task automatic test_sensing_disabled();
        write_config(REG_SENSING_ENABLE, 32'd0);
        repeat (40) begin
            if ($urandom_range(0, 4) == 0) send_byte(CH_LF);
            else send_byte(8'($urandom_range(0, 255)));
        end
        send_valid_write(1'b1);
        write_config(REG_SENSING_ENABLE, 32'd1);
    endtask

    // Mostly well-formed sentences with random content, some noise
    task automatic test_random_sentences(int count, bit no_idle);
        int target;
        target = items_sent + count;
        calm   = no_idle;
        while (items_sent < target) begin
            make_line();
            foreach (line_bytes[i]) begin
                if ($urandom_range(0, 99) < 3) send_valid_write(1'($urandom_range(0, 1)));
                send_byte(line_bytes[i]);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        apply_reset();
        test_directed_cases();
        test_random_sentences(800, 1'b0);
        test_sensing_disabled();
        test_random_sentences(400, 1'b1);
        test_random_sentences(500, 1'b0);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/nmeadt_pkg.sv
hdl/nmeadt_core.sv
hdl/nmea_depth_temp_sentence_parser.sv
verif/tb.sv
